[rtl/core/vvfs_pkg.sv]
// Shared constants, codes and types of the voxel visible-face scan core.
package vvfs_pkg;

    // Chunk edge length, clamped to the row width.
    localparam int CHUNK_SIZE = 32;
    localparam int ROW_W      = 32;
    localparam int X_W        = 5;
    localparam int SZ         = (CHUNK_SIZE < ROW_W) ? CHUNK_SIZE : ROW_W;
    localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((64'(1) << SZ) - 64'(1));
    localparam logic [X_W-1:0]   LAST_IDX = X_W'(SZ - 1);

    // Store geometry.
    localparam int CHUNK_DEPTH = 1024;
    localparam int FACE_DEPTH  = 192;
    localparam int CHUNK_AW    = $clog2(CHUNK_DEPTH);
    localparam int FACE_AW     = $clog2(FACE_DEPTH);

    // Faces and boundary sides, bit order -x,-y,-z,+x,+y,+z.
    localparam int FACE_N  = 6;
    localparam int SIDE_W  = 3;
    localparam logic [SIDE_W-1:0] SIDE_NX = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_NY = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_NZ = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_PX = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_PY = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_PZ = 3'd5;
    localparam logic [SIDE_W-1:0] SIDE_END = 3'd6;

    // Fetch steps: one chunk row and one boundary row per step.
    localparam logic [SIDE_W-1:0] STEP_SELF = 3'd0;
    localparam logic [SIDE_W-1:0] STEP_YM   = 3'd1;
    localparam logic [SIDE_W-1:0] STEP_YP   = 3'd2;
    localparam logic [SIDE_W-1:0] STEP_ZM   = 3'd3;
    localparam logic [SIDE_W-1:0] STEP_ZP   = 3'd4;

    // Operation codes.
    typedef enum logic [1:0] {
        FUNC_LOAD_CHUNK = 2'd0,
        FUNC_LOAD_FACE  = 2'd1,
        FUNC_SCAN       = 2'd2,
        FUNC_NOP        = 2'd3
    } vvfs_func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL
    } vvfs_state_t;

    // Neighbour solid bits and border flags handed to one lane.
    typedef struct packed {
        logic              solid;
        logic [FACE_N-1:0] nbr;
        logic [FACE_N-1:0] border;
    } vvfs_lane_in_t;

    // True when a row index lies inside the chunk.
    function automatic logic idx_ok(input logic [X_W-1:0] idx);
        idx_ok = ((X_W+1)'(idx) < (X_W+1)'(SZ));
    endfunction

endpackage

[rtl/core/vvfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vvfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/vvfs_lane.sv]
// One face-visibility lane: the six-face mask of a single voxel position.
module vvfs_lane (
    input  vvfs_pkg::vvfs_lane_in_t      lane_in,
    input  logic [vvfs_pkg::FACE_N-1:0]  present,
    output logic [vvfs_pkg::FACE_N-1:0]  mask,
    output logic                         visible
);
    import vvfs_pkg::*;

    logic [FACE_N-1:0] open_face;

    // Inside the chunk a face is open when the neighbour is empty; across
    // the border an absent neighbour chunk also opens it.
    always_comb
    begin
        for (int f = 0; f < FACE_N; f++)
        begin
            if (lane_in.border[f])
            begin
                open_face[f] = ~present[f] | ~lane_in.nbr[f];
            end
            else
            begin
                open_face[f] = ~lane_in.nbr[f];
            end
        end
        mask    = lane_in.solid ? open_face : '0;
        visible = |mask;
    end

endmodule

[rtl/core/vvfs_merge.sv]
// Merge stage: emits the visible lanes of a scan in increasing x.
module vvfs_merge (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  logic [vvfs_pkg::ROW_W-1:0]                    vis,
    input  logic [vvfs_pkg::ROW_W-1:0][vvfs_pkg::FACE_N-1:0] masks,
    input  logic                                          out_stall,
    output logic                                          out_valid,
    output logic [vvfs_pkg::X_W-1:0]                      voxel_x,
    output logic [vvfs_pkg::FACE_N-1:0]                   face_mask,
    output logic                                          last_in_row,
    output logic                                          busy
);
    import vvfs_pkg::*;

    logic [ROW_W-1:0]             pend_reg, pend_next;
    logic [ROW_W-1:0][FACE_N-1:0] mask_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [X_W-1:0]               voxel_x_reg;
    logic [FACE_N-1:0]            face_mask_reg;
    logic                         last_reg;
    logic [ROW_W-1:0]             low_oh;
    logic [X_W-1:0]               low_idx;
    logic [FACE_N-1:0]            low_mask;
    logic                         pop;

    // Lowest pending lane as a one-hot word, then encoded.
    always_comb
    begin
        low_oh   = pend_reg & (~pend_reg + ROW_W'(1));
        low_idx  = '0;
        low_mask = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (low_oh[i])
            begin
                low_idx  = low_idx | X_W'(i);
                low_mask = low_mask | mask_reg[i];
            end
        end
    end

    // Move one result into the output register whenever it is free.
    always_comb
    begin
        pop            = (pend_reg != '0) && (!out_valid_reg || !out_stall);
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            pend_next = vis;
        end
        else if (pop)
        begin
            pend_next = pend_reg & ~low_oh;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mask_reg <= masks;
        end
        if (pop)
        begin
            voxel_x_reg   <= low_idx;
            face_mask_reg <= low_mask;
            last_reg      <= ((pend_reg & ~low_oh) == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign voxel_x     = voxel_x_reg;
    assign face_mask   = face_mask_reg;
    assign last_in_row = last_reg;
    assign busy        = (pend_reg != '0);

endmodule

[rtl/core/voxel_visible_face_scan_core.sv]
// Top level of the voxel visible-face scan core: stores, fetch sequencer, lanes, merge.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+------------------------------------------
//  in       | in_valid / in_stall          | func, row_y, row_z, side, row_bits
//  out      | out_valid / out_stall        | voxel_x, face_mask, last_in_row
//  config   | neighbor_present_we          | neighbor_present
//
//  A scan reads its five chunk rows and six boundary rows through the single read port of
//  each store, evaluates all 32 lanes, then emits one result per cycle while out_stall is
//  low; the next transaction is taken only once the sequencer is idle and the merge stage
//  holds no pending results.
//  Reset clears the control state and the neighbor_present register; the stores are not
//  cleared. A stalled output holds its result and the merge stage waits.
module voxel_visible_face_scan_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         neighbor_present_we,
    input  logic [vvfs_pkg::FACE_N-1:0]  neighbor_present,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [vvfs_pkg::X_W-1:0]     row_y,
    input  logic [vvfs_pkg::X_W-1:0]     row_z,
    input  logic [vvfs_pkg::SIDE_W-1:0]  side,
    input  logic [vvfs_pkg::ROW_W-1:0]   row_bits,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vvfs_pkg::X_W-1:0]     voxel_x,
    output logic [vvfs_pkg::FACE_N-1:0]  face_mask,
    output logic                         last_in_row
);
    import vvfs_pkg::*;

    vvfs_state_t       state_reg, state_next;
    logic [SIDE_W-1:0] step_reg, step_next;
    logic [SIDE_W-1:0] step_prev;
    logic [FACE_N-1:0] present_reg;
    logic [X_W-1:0]    y_reg, z_reg;
    logic [ROW_W-1:0]  row_c_reg, row_ym_reg, row_yp_reg, row_zm_reg, row_zp_reg;
    logic [ROW_W-1:0]  nf_reg [FACE_N];

    logic              in_accept;
    logic              scan_go;
    logic              merge_busy;
    vvfs_func_t        func_code;

    logic              chunk_we, face_we;
    logic [CHUNK_AW-1:0] chunk_waddr, chunk_raddr;
    logic [FACE_AW-1:0]  face_waddr, face_raddr;
    logic [ROW_W-1:0]  chunk_rdata, face_rdata;
    logic [X_W-1:0]    face_row;

    vvfs_lane_in_t               lane_in [ROW_W];
    logic [ROW_W-1:0][FACE_N-1:0] lane_mask;
    logic [ROW_W-1:0]            lane_vis;
    logic                        y_lo, y_hi, z_lo, z_hi;

    // Input handshake and decoding of the transaction.
    assign func_code = vvfs_func_t'(func);
    assign in_stall  = (state_reg != ST_IDLE) || merge_busy;
    assign in_accept = in_valid && !in_stall;
    assign scan_go   = in_accept && (func_code == FUNC_SCAN) && idx_ok(row_y) && idx_ok(row_z);

    // Store write ports, driven straight from an accepted load.
    assign chunk_we    = in_accept && (func_code == FUNC_LOAD_CHUNK)
                         && idx_ok(row_y) && idx_ok(row_z);
    assign chunk_waddr = {row_z, row_y};
    assign face_we     = in_accept && (func_code == FUNC_LOAD_FACE)
                         && (side < SIDE_END) && idx_ok(row_z);
    assign face_waddr  = {side, row_z};

    vvfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHUNK_DEPTH)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (chunk_we),
        .waddr (chunk_waddr),
        .wdata (row_bits & ROW_MASK),
        .raddr (chunk_raddr),
        .rdata (chunk_rdata)
    );

    vvfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (FACE_DEPTH)
    ) u_face_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (face_waddr),
        .wdata (row_bits & ROW_MASK),
        .raddr (face_raddr),
        .rdata (face_rdata)
    );

    // Read addresses for the current fetch step.
    always_comb
    begin
        unique case (step_reg)
            STEP_YM: chunk_raddr = {z_reg, y_reg - X_W'(1)};
            STEP_YP: chunk_raddr = {z_reg, y_reg + X_W'(1)};
            STEP_ZM: chunk_raddr = {z_reg - X_W'(1), y_reg};
            STEP_ZP: chunk_raddr = {z_reg + X_W'(1), y_reg};
            default: chunk_raddr = {z_reg, y_reg};
        endcase
        face_row   = ((step_reg == SIDE_NZ) || (step_reg == SIDE_PZ)) ? y_reg : z_reg;
        face_raddr = (step_reg < SIDE_END) ? {step_reg, face_row} : '0;
        step_prev  = step_reg - SIDE_W'(1);
    end

    // Sequencer: fetch rows, then hand the lanes' results to the merge stage.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (scan_go)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                step_next = step_reg + SIDE_W'(1);
                if (step_reg == SIDE_END)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Control registers and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            present_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (neighbor_present_we)
            begin
                present_reg <= neighbor_present;
            end
        end
    end

    // Row coordinates and fetched rows; read data comes from the registered store output.
    always_ff @(posedge clk)
    begin
        if (scan_go)
        begin
            y_reg <= row_y;
            z_reg <= row_z;
        end
        if ((state_reg == ST_FETCH) && (step_reg != STEP_SELF))
        begin
            nf_reg[step_prev] <= face_rdata;
            unique case (step_prev)
                STEP_SELF: row_c_reg  <= chunk_rdata;
                STEP_YM:   row_ym_reg <= chunk_rdata;
                STEP_YP:   row_yp_reg <= chunk_rdata;
                STEP_ZM:   row_zm_reg <= chunk_rdata;
                STEP_ZP:   row_zp_reg <= chunk_rdata;
                default:   ;
            endcase
        end
    end

    // Border flags shared by all lanes.
    assign y_lo = (y_reg == '0);
    assign y_hi = (y_reg == LAST_IDX);
    assign z_lo = (z_reg == '0);
    assign z_hi = (z_reg == LAST_IDX);

    // One lane per x position.
    for (genvar X = 0; X < ROW_W; X++)
    begin : g_lane
        always_comb
        begin
            lane_in[X].solid = row_c_reg[X] & ROW_MASK[X];

            if (X == 0)
            begin
                lane_in[X].nbr[SIDE_NX]    = nf_reg[SIDE_NX][y_reg];
                lane_in[X].border[SIDE_NX] = 1'b1;
            end
            else
            begin
                lane_in[X].nbr[SIDE_NX]    = row_c_reg[(X+ROW_W-1)%ROW_W];
                lane_in[X].border[SIDE_NX] = 1'b0;
            end

            if (X == SZ - 1)
            begin
                lane_in[X].nbr[SIDE_PX]    = nf_reg[SIDE_PX][y_reg];
                lane_in[X].border[SIDE_PX] = 1'b1;
            end
            else
            begin
                lane_in[X].nbr[SIDE_PX]    = row_c_reg[(X+1)%ROW_W];
                lane_in[X].border[SIDE_PX] = 1'b0;
            end

            lane_in[X].nbr[SIDE_NY]    = y_lo ? nf_reg[SIDE_NY][X] : row_ym_reg[X];
            lane_in[X].border[SIDE_NY] = y_lo;
            lane_in[X].nbr[SIDE_PY]    = y_hi ? nf_reg[SIDE_PY][X] : row_yp_reg[X];
            lane_in[X].border[SIDE_PY] = y_hi;
            lane_in[X].nbr[SIDE_NZ]    = z_lo ? nf_reg[SIDE_NZ][X] : row_zm_reg[X];
            lane_in[X].border[SIDE_NZ] = z_lo;
            lane_in[X].nbr[SIDE_PZ]    = z_hi ? nf_reg[SIDE_PZ][X] : row_zp_reg[X];
            lane_in[X].border[SIDE_PZ] = z_hi;
        end

        vvfs_lane u_lane (
            .lane_in (lane_in[X]),
            .present (present_reg),
            .mask    (lane_mask[X]),
            .visible (lane_vis[X])
        );
    end

    // Merge stage and output register.
    vvfs_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (state_reg == ST_EVAL),
        .vis         (lane_vis),
        .masks       (lane_mask),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .voxel_x     (voxel_x),
        .face_mask   (face_mask),
        .last_in_row (last_in_row),
        .busy        (merge_busy)
    );

endmodule
